FILE: sv/ddfr_pkg.sv
`default_nettype none
package ddfr_pkg;

    // payload store geometry
    localparam int PAYLOAD_DEPTH = 64;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_W         = 7;
    localparam int IDX_W         = 6;

    // queue sizes between the parts
    localparam int IQ_DEPTH = 2;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // fixed frame bytes
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // register map and reset values
    localparam logic [2:0] ADDR_START_A  = 3'd0;
    localparam logic [2:0] ADDR_START_B  = 3'd4;
    localparam logic [7:0] START_A_RESET = 8'hC0;
    localparam logic [7:0] START_B_RESET = 8'hC1;

    // command codes on the input word
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BYTE,
        OP_CLEAR,
        OP_READ
    } t_op_kind;

    typedef enum logic [1:0] {
        PH_WAIT_START,
        PH_IN_PACKET,
        PH_WAIT_CR,
        PH_WAIT_LF
    } t_phase;

    // decoded word from the front part
    typedef struct packed {
        t_op_kind         kind;
        logic [7:0]       rx_byte;
        logic             channel;
        logic [IDX_W-1:0] read_index;
    } t_op;

    // per-channel command
    typedef struct packed {
        logic             byte_en;
        logic             clear;
        logic             read;
        logic [7:0]       rx_byte;
        logic [IDX_W-1:0] read_index;
    } t_chan_cmd;

    // per-channel status
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] count;
    } t_chan_stat;

    // result word
    typedef struct packed {
        logic             ready_a;
        logic             ready_b;
        logic [LEN_W-1:0] length_a;
        logic [LEN_W-1:0] length_b;
        logic [7:0]       read_data;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/ddfr_front.sv
`default_nettype none
module ddfr_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_channel,
    input  wire logic [ddfr_pkg::IDX_W-1:0] i_read_index,
    output logic                           o_valid,
    output ddfr_pkg::t_op                  o_op,
    input  wire logic                      i_take
);

    ddfr_pkg::t_op                      r_slot [ddfr_pkg::IQ_DEPTH];
    logic [ddfr_pkg::IQ_PTR_W-1:0]      r_wr_ptr;
    logic [ddfr_pkg::IQ_PTR_W-1:0]      r_rd_ptr;
    logic [ddfr_pkg::IQ_CNT_W-1:0]      r_count;
    ddfr_pkg::t_op                      n_op;
    logic                               w_wr;
    logic                               w_rd;

    // classify the incoming word
    always_comb begin
        n_op.rx_byte    = i_rx_byte;
        n_op.channel    = i_channel;
        n_op.read_index = i_read_index;
        case (i_cmd)
            ddfr_pkg::CMD_BYTE:  n_op.kind = ddfr_pkg::OP_BYTE;
            ddfr_pkg::CMD_CLEAR: n_op.kind = ddfr_pkg::OP_CLEAR;
            ddfr_pkg::CMD_READ:  n_op.kind = ddfr_pkg::OP_READ;
            default:             n_op.kind = ddfr_pkg::OP_NONE;
        endcase
    end

    assign full    = (r_count == ddfr_pkg::IQ_CNT_W'(ddfr_pkg::IQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_valid;

    // queue slots
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= n_op;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/ddfr_chan.sv
`default_nettype none
module ddfr_chan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_start_byte,
    input  wire ddfr_pkg::t_chan_cmd i_cmd,
    output ddfr_pkg::t_chan_stat     o_stat,
    output logic [7:0]               o_rd_data
);

    logic [7:0]                    r_store [ddfr_pkg::PAYLOAD_DEPTH];
    ddfr_pkg::t_phase              r_phase;
    ddfr_pkg::t_phase              n_phase;
    logic [ddfr_pkg::LEN_W-1:0]    r_count;
    logic [ddfr_pkg::LEN_W-1:0]    n_count;
    logic                          r_done;
    logic                          n_done;
    logic                          w_wr;
    logic                          w_is_delim;
    logic                          w_has_room;
    logic [7:0]                    r_rd_q;
    logic                          r_rd_ok;

    assign w_is_delim = (i_cmd.rx_byte == i_start_byte);
    assign w_has_room = (r_count < ddfr_pkg::LEN_W'(ddfr_pkg::PAYLOAD_DEPTH));

    // phase, count and done update
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_done  = r_done;
        w_wr    = 1'b0;
        if (i_cmd.clear) begin
            n_count = '0;
            n_done  = 1'b0;
        end else if (i_cmd.byte_en && !r_done) begin
            case (r_phase)
                ddfr_pkg::PH_WAIT_START: begin
                    if (w_is_delim) begin
                        n_count = '0;
                        n_phase = ddfr_pkg::PH_IN_PACKET;
                    end
                end
                ddfr_pkg::PH_IN_PACKET: begin
                    if (w_is_delim) begin
                        n_phase = ddfr_pkg::PH_WAIT_CR;
                    end else if (w_has_room) begin
                        w_wr    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                ddfr_pkg::PH_WAIT_CR: begin
                    if (i_cmd.rx_byte == ddfr_pkg::BYTE_CR) begin
                        n_phase = ddfr_pkg::PH_WAIT_LF;
                    end else if (w_is_delim) begin
                        n_count = '0;
                        n_phase = ddfr_pkg::PH_IN_PACKET;
                    end else begin
                        n_phase = ddfr_pkg::PH_WAIT_START;
                    end
                end
                ddfr_pkg::PH_WAIT_LF: begin
                    if (i_cmd.rx_byte == ddfr_pkg::BYTE_LF) begin
                        n_done = 1'b1;
                    end
                    n_phase = ddfr_pkg::PH_WAIT_START;
                end
                default: begin
                    n_phase = ddfr_pkg::PH_WAIT_START;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ddfr_pkg::PH_WAIT_START;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_done  <= n_done;
            r_rd_ok <= i_cmd.read
                       && (ddfr_pkg::LEN_W'(i_cmd.read_index) < r_count);
        end
    end

    // payload store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[r_count[ddfr_pkg::ADDR_W-1:0]] <= i_cmd.rx_byte;
        end
        r_rd_q <= r_store[ddfr_pkg::ADDR_W'(i_cmd.read_index)];
    end

    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;
    assign o_rd_data    = r_rd_ok ? r_rd_q : 8'h00;

endmodule
`default_nettype wire

FILE: sv/ddfr_result_q.sv
`default_nettype none
module ddfr_result_q (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_wr,
    input  wire ddfr_pkg::t_result           i_word,
    input  wire logic                        pop,
    output logic                             empty,
    output ddfr_pkg::t_result                o_word,
    output logic [ddfr_pkg::OQ_CNT_W-1:0]    o_count
);

    ddfr_pkg::t_result                  r_slot [ddfr_pkg::OQ_DEPTH];
    logic [ddfr_pkg::OQ_PTR_W-1:0]      r_wr_ptr;
    logic [ddfr_pkg::OQ_PTR_W-1:0]      r_rd_ptr;
    logic [ddfr_pkg::OQ_CNT_W-1:0]      r_count;
    logic                               w_rd;

    assign empty   = (r_count == '0);
    assign o_word  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign w_rd    = pop && !empty;

    // result slots
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/dual_delimited_frame_receiver_core.sv
// Two frame receivers watch one byte stream for frames of the form start byte,
// payload, start byte, CR, LF; channel A and B each have their own start byte
// (registers at 0x0 and 0x4, reset 0xC0 and 0xC1) and a 64-byte payload store.
// Words go in through push/full and every word gives one result word out
// through empty/pop. One word is taken per clock cycle while the result
// queue has room. A result passes through the two-entry input queue, the
// channel update stage with its registered store read, and the four-entry
// result queue. A full result queue holds the input side back. The user is
// to change start bytes only while the block is idle; the block does not check.
`default_nettype none
module dual_delimited_frame_receiver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_channel,
    input  wire logic [5:0]  i_read_index,
    // result word
    output logic             empty,
    input  wire logic        pop,
    output logic             o_ready_a,
    output logic             o_ready_b,
    output logic [6:0]       o_length_a,
    output logic [6:0]       o_length_b,
    output logic [7:0]       o_read_data,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                               w_head_valid;
    ddfr_pkg::t_op                      w_head_op;
    logic                               w_issue;
    logic                               r_s2_valid;
    logic [ddfr_pkg::OQ_CNT_W-1:0]      w_oq_count;
    ddfr_pkg::t_chan_cmd                w_cmd_a;
    ddfr_pkg::t_chan_cmd                w_cmd_b;
    ddfr_pkg::t_chan_stat               w_stat_a;
    ddfr_pkg::t_chan_stat               w_stat_b;
    logic [7:0]                         w_rd_a;
    logic [7:0]                         w_rd_b;
    ddfr_pkg::t_result                  w_result;
    ddfr_pkg::t_result                  w_out;
    logic [7:0]                         r_start_a;
    logic [7:0]                         r_start_b;
    logic                               w_cfg_wr;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_a <= ddfr_pkg::START_A_RESET;
            r_start_b <= ddfr_pkg::START_B_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == ddfr_pkg::ADDR_START_B[2]) begin
                r_start_b <= pwdata[7:0];
            end else begin
                r_start_a <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ddfr_pkg::ADDR_START_B[2]) begin
            prdata = {24'h000000, r_start_b};
        end else begin
            prdata = {24'h000000, r_start_a};
        end
    end

    // front: accept and classify
    ddfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .i_channel    (i_channel),
        .i_read_index (i_read_index),
        .o_valid      (w_head_valid),
        .o_op         (w_head_op),
        .i_take       (w_issue)
    );

    // issue only with a free result slot for every word in flight
    assign w_issue = w_head_valid
                     && ((w_oq_count + ddfr_pkg::OQ_CNT_W'(r_s2_valid))
                         < ddfr_pkg::OQ_CNT_W'(ddfr_pkg::OQ_DEPTH));

    // per-channel commands
    always_comb begin
        w_cmd_a.byte_en    = w_issue && (w_head_op.kind == ddfr_pkg::OP_BYTE);
        w_cmd_a.clear      = w_issue && (w_head_op.kind == ddfr_pkg::OP_CLEAR)
                             && !w_head_op.channel;
        w_cmd_a.read       = w_issue && (w_head_op.kind == ddfr_pkg::OP_READ)
                             && !w_head_op.channel;
        w_cmd_a.rx_byte    = w_head_op.rx_byte;
        w_cmd_a.read_index = w_head_op.read_index;
        w_cmd_b.byte_en    = w_cmd_a.byte_en;
        w_cmd_b.clear      = w_issue && (w_head_op.kind == ddfr_pkg::OP_CLEAR)
                             && w_head_op.channel;
        w_cmd_b.read       = w_issue && (w_head_op.kind == ddfr_pkg::OP_READ)
                             && w_head_op.channel;
        w_cmd_b.rx_byte    = w_head_op.rx_byte;
        w_cmd_b.read_index = w_head_op.read_index;
    end

    // back: the two receivers
    ddfr_chan u_chan_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_start_a),
        .i_cmd        (w_cmd_a),
        .o_stat       (w_stat_a),
        .o_rd_data    (w_rd_a)
    );

    ddfr_chan u_chan_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_start_b),
        .i_cmd        (w_cmd_b),
        .o_stat       (w_stat_b),
        .o_rd_data    (w_rd_b)
    );

    // word issued last cycle now has its state and read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_issue;
        end
    end

    assign w_result.ready_a   = w_stat_a.done;
    assign w_result.ready_b   = w_stat_b.done;
    assign w_result.length_a  = w_stat_a.count;
    assign w_result.length_b  = w_stat_b.count;
    assign w_result.read_data = w_rd_a | w_rd_b;

    // result queue
    ddfr_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_s2_valid),
        .i_word  (w_result),
        .pop     (pop),
        .empty   (empty),
        .o_word  (w_out),
        .o_count (w_oq_count)
    );

    assign o_ready_a   = w_out.ready_a;
    assign o_ready_b   = w_out.ready_b;
    assign o_length_a  = w_out.length_a;
    assign o_length_b  = w_out.length_b;
    assign o_read_data = w_out.read_data;

`ifndef SYNTHESIS
    // a finished word always finds a free result slot
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (w_oq_count < ddfr_pkg::OQ_CNT_W'(ddfr_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

    // stored length never passes the store depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat_a.count <= ddfr_pkg::LEN_W'(ddfr_pkg::PAYLOAD_DEPTH))
        && (w_stat_b.count <= ddfr_pkg::LEN_W'(ddfr_pkg::PAYLOAD_DEPTH)))
        else $error("payload length beyond store depth");

    // a clear empties its channel in the following cycle
    a_clear_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_a.clear |=> (!w_stat_a.done && (w_stat_a.count == '0)))
        else $error("channel A not cleared");

    // read data only where a read of that channel was issued
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd_a.read && !w_cmd_b.read |=> (w_result.read_data == 8'h00))
        else $error("read data without read");
`endif

endmodule
`default_nettype wire
